// ===== hw/rtl/psp_pkg.sv =====
// Shared constants and codes for the predictive stack parser.
package psp_pkg;

  // Default sizes of the rule table, the parse stack and the expansion budget.
  localparam int DefRuleSlots    = 16;
  localparam int DefRuleSymbols  = 8;
  localparam int DefStackDepth   = 64;
  localparam int DefMaxExpansions = 64;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgRuleCount   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartSymbol = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEpsSymbol   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgEndMarker   = 2'd3;

  localparam logic [4:0] RstRuleCount   = 5'd0;
  localparam logic [7:0] RstStartSymbol = 8'd83;
  localparam logic [7:0] RstEpsSymbol   = 8'd101;
  localparam logic [7:0] RstEndMarker   = 8'd36;

  // Request opcodes.
  localparam logic [1:0] OpWrite = 2'd0;
  localparam logic [1:0] OpStart = 2'd1;
  localparam logic [1:0] OpFeed  = 2'd2;

  // Result status codes; the first three double as the parse verdict.
  localparam logic [1:0] StRunning = 2'd0;
  localparam logic [1:0] StAccept  = 2'd1;
  localparam logic [1:0] StReject  = 2'd2;
  localparam logic [1:0] StDecided = 2'd3;

  // Reject causes.
  localparam logic [1:0] CauseNone     = 2'd0;
  localparam logic [1:0] CauseNoRule   = 2'd1;
  localparam logic [1:0] CauseOverflow = 2'd2;
  localparam logic [1:0] CauseLimit    = 2'd3;

endpackage

// ===== hw/rtl/psp_ram.sv =====
// Generic one-write, one-read RAM with registered read data.
module psp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/predictive_stack_parser_core.sv =====
// Top level of the predictive stack parser: sequencer, rule tables and parse stack.
// Writes and unused opcodes go straight to the result; a start pushes the end and start symbols.
// A fed symbol to a decided parse reports StDecided; else the stack top is read, a match popped;
// an expansion step scans each rule in use, then pushes the chosen body symbols one by one.
// One request is in work at a time; a new one is taken once the result is registered.
// Reset clears the stack pointer and verdict; payload, rule and stack memories are not cleared.
module predictive_stack_parser_core #(
  parameter int RULE_SLOTS     = psp_pkg::DefRuleSlots,
  parameter int RULE_SYMBOLS   = psp_pkg::DefRuleSymbols,
  parameter int STACK_DEPTH    = psp_pkg::DefStackDepth,
  parameter int MAX_EXPANSIONS = psp_pkg::DefMaxExpansions
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [psp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [3:0]                    rule_index_i,
  input  logic [2:0]                    rule_position_i,
  input  logic [3:0]                    rule_length_i,
  input  logic [7:0]                    symbol_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [1:0]                    reject_cause_o,
  output logic [6:0]                    stack_depth_o
);
  import psp_pkg::*;

  localparam int RIdxW  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int UseW   = ($clog2(RULE_SLOTS + 1) > 5) ? $clog2(RULE_SLOTS + 1) : 5;
  localparam int SymW   = $clog2(RULE_SYMBOLS);
  localparam int RsAW   = $clog2(RULE_SLOTS * RULE_SYMBOLS);
  localparam int SpW    = $clog2(STACK_DEPTH + 1);
  localparam int SaW    = $clog2(STACK_DEPTH);
  localparam int OvW    = $clog2(STACK_DEPTH + RULE_SYMBOLS + 1);
  localparam int ExW    = $clog2(MAX_EXPANSIONS + 1);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_START   = 11'b000_0000_0010,
    S_TOP_RD  = 11'b000_0000_0100,
    S_TOP_CK  = 11'b000_0000_1000,
    S_LHS_RD  = 11'b000_0001_0000,
    S_LHS_CK  = 11'b000_0010_0000,
    S_BODY_CK = 11'b000_0100_0000,
    S_DECIDE  = 11'b000_1000_0000,
    S_PUSH_RD = 11'b001_0000_0000,
    S_PUSH_WR = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_e;

  // Flat rule-table address of one symbol of one rule.
  function automatic logic [RsAW-1:0] rs_addr(logic [RIdxW-1:0] r, logic [SymW-1:0] p);
    return RsAW'(int'(r) * RULE_SYMBOLS + int'(p));
  endfunction

  // Body symbol count from a stored rule length.
  function automatic logic [SymW-1:0] body_cnt(logic [3:0] len);
    logic [5:0] l;
    l = {2'b00, len};
    if (l > 6'(RULE_SYMBOLS)) l = 6'(RULE_SYMBOLS);
    if (l == 6'd0) l = 6'd1;
    return SymW'(l - 6'd1);
  endfunction

  state_e            state_q, state_d;
  logic [SpW-1:0]    sp_q, sp_d;
  logic [1:0]        verdict_q, verdict_d;
  logic [4:0]        rule_count_q, rule_count_d;
  logic [7:0]        start_q, start_d, eps_q, eps_d, end_q, end_d;
  logic [7:0]        sym_q, sym_d, top_q, top_d;
  logic [UseW-1:0]   r_q, r_d;
  logic [1:0]        m_q, m_d;
  logic              have_q, have_d, can_null_q, can_null_d, first_empty_q, first_empty_d;
  logic [RIdxW-1:0]  first_q, first_d, chosen_q, chosen_d;
  logic [SymW-1:0]   first_bc_q, first_bc_d, chosen_bc_q, chosen_bc_d, j_q, j_d;
  logic [ExW-1:0]    exp_q, exp_d;
  logic [1:0]        status_q, status_d, cause_q, cause_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_status_q, out_status_d, out_cause_q, out_cause_d;
  logic [6:0]        out_depth_q, out_depth_d;

  logic              in_acc;
  logic [UseW-1:0]   used, idx_w;
  logic [5:0]        pos_w;
  logic              idx_ok, pos_ok;
  logic              rs_we, len_we, stk_we;
  logic [RsAW-1:0]   rs_waddr, rs_raddr;
  logic [7:0]        rs_rdata;
  logic [RIdxW-1:0]  len_raddr;
  logic [3:0]        len_rdata;
  logic [SaW-1:0]    stk_waddr, stk_raddr;
  logic [7:0]        stk_wdata, stk_rdata;
  logic [SymW-1:0]   bc;
  logic              empty_body;
  logic              dec_reject, dec_pop;
  logic [RIdxW-1:0]  dec_rule;
  logic [SymW-1:0]   dec_bc;

  assign in_stall_o     = (state_q != S_IDLE);
  assign in_acc         = in_valid_i && !in_stall_o;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign reject_cause_o = out_cause_q;
  assign stack_depth_o  = out_depth_q;

  // Rule-write decode.
  assign used   = (UseW'(rule_count_q) > UseW'(RULE_SLOTS)) ? UseW'(RULE_SLOTS)
                                                             : UseW'(rule_count_q);
  assign idx_w  = UseW'(rule_index_i);
  assign pos_w  = 6'(rule_position_i);
  assign idx_ok = idx_w < UseW'(RULE_SLOTS);
  assign pos_ok = pos_w < 6'(RULE_SYMBOLS);
  assign rs_we  = in_acc && (opcode_i == OpWrite) && idx_ok && pos_ok;
  assign len_we = in_acc && (opcode_i == OpWrite) && idx_ok;
  assign rs_waddr = rs_addr(idx_w[RIdxW-1:0], pos_w[SymW-1:0]);

  // Properties of the rule just read during the scan.
  assign bc         = body_cnt(len_rdata);
  assign empty_body = (bc == '0) || (rs_rdata == eps_q);

  // Choice of action once the rule scan has finished.
  always_comb begin
    dec_reject = 1'b0;
    dec_pop    = 1'b0;
    dec_rule   = chosen_q;
    dec_bc     = chosen_bc_q;
    if (m_q == 2'd0) begin
      dec_reject = 1'b1;
    end else if (m_q == 2'd1) begin
      dec_pop  = first_empty_q;
      dec_rule = first_q;
      dec_bc   = first_bc_q;
    end else if (!have_q) begin
      if (can_null_q) begin
        dec_pop = 1'b1;
      end else begin
        dec_reject = 1'b1;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    sp_d          = sp_q;
    verdict_d     = verdict_q;
    rule_count_d  = rule_count_q;
    start_d       = start_q;
    eps_d         = eps_q;
    end_d         = end_q;
    sym_d         = sym_q;
    top_d         = top_q;
    r_d           = r_q;
    m_d           = m_q;
    have_d        = have_q;
    can_null_d    = can_null_q;
    first_empty_d = first_empty_q;
    first_d       = first_q;
    chosen_d      = chosen_q;
    first_bc_d    = first_bc_q;
    chosen_bc_d   = chosen_bc_q;
    j_d           = j_q;
    exp_d         = exp_q;
    status_d      = status_q;
    cause_d       = cause_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_cause_d   = out_cause_q;
    out_depth_d   = out_depth_q;
    rs_raddr      = rs_addr(r_q[RIdxW-1:0], '0);
    len_raddr     = r_q[RIdxW-1:0];
    stk_we        = 1'b0;
    stk_waddr     = SaW'(sp_q);
    stk_wdata     = rs_rdata;
    stk_raddr     = SaW'(sp_q - SpW'(1));

    // Configuration writes.
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRuleCount:   rule_count_d = cfg_data_i[4:0];
        CfgStartSymbol: start_d      = cfg_data_i;
        CfgEpsSymbol:   eps_d        = cfg_data_i;
        CfgEndMarker:   end_d        = cfg_data_i;
        default:        ;
      endcase
    end

    // Result register drains when taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          status_d = StRunning;
          cause_d  = CauseNone;
          sym_d    = symbol_i;
          state_d  = S_DONE;
          unique case (opcode_i)
            OpStart: begin
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = end_q;
              state_d   = S_START;
            end
            OpFeed: begin
              if (verdict_q != StRunning) begin
                status_d = StDecided;
              end else begin
                exp_d   = '0;
                state_d = S_TOP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_START: begin
        stk_we    = 1'b1;
        stk_waddr = SaW'(1);
        stk_wdata = start_q;
        sp_d      = SpW'(2);
        verdict_d = StRunning;
        state_d   = S_DONE;
      end
      S_TOP_RD: begin
        if (sp_q == '0) begin
          verdict_d = StReject;
          status_d  = StReject;
          cause_d   = CauseNoRule;
          state_d   = S_DONE;
        end else begin
          state_d = S_TOP_CK;
        end
      end
      S_TOP_CK: begin
        top_d = stk_rdata;
        if (stk_rdata == end_q) begin
          if (sym_q == end_q) begin
            verdict_d = StAccept;
            status_d  = StAccept;
          end else begin
            verdict_d = StReject;
            status_d  = StReject;
            cause_d   = CauseNoRule;
          end
          state_d = S_DONE;
        end else if (stk_rdata == sym_q) begin
          sp_d    = sp_q - SpW'(1);
          state_d = S_DONE;
        end else begin
          r_d        = '0;
          m_d        = 2'd0;
          have_d     = 1'b0;
          can_null_d = 1'b0;
          state_d    = S_LHS_RD;
        end
      end
      S_LHS_RD: begin
        if (r_q >= used) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_LHS_CK;
        end
      end
      S_LHS_CK: begin
        if (rs_rdata == top_q) begin
          m_d = (m_q == 2'd2) ? 2'd2 : m_q + 2'd1;
          if (m_q == 2'd0) begin
            first_d = r_q[RIdxW-1:0];
          end
          if (!have_q) begin
            rs_raddr = rs_addr(r_q[RIdxW-1:0], SymW'(1));
            state_d  = S_BODY_CK;
          end else begin
            r_d     = r_q + UseW'(1);
            state_d = S_LHS_RD;
          end
        end else begin
          r_d     = r_q + UseW'(1);
          state_d = S_LHS_RD;
        end
      end
      S_BODY_CK: begin
        if (m_q == 2'd1) begin
          first_empty_d = empty_body;
          first_bc_d    = bc;
        end
        if ((bc != '0) && (rs_rdata == sym_q)) begin
          chosen_d    = r_q[RIdxW-1:0];
          chosen_bc_d = bc;
          have_d      = 1'b1;
        end else if (empty_body) begin
          can_null_d = 1'b1;
        end
        r_d     = r_q + UseW'(1);
        state_d = S_LHS_RD;
      end
      S_DECIDE: begin
        state_d = S_DONE;
        if (dec_reject) begin
          verdict_d = StReject;
          status_d  = StReject;
          cause_d   = CauseNoRule;
        end else if (exp_q >= ExW'(MAX_EXPANSIONS)) begin
          verdict_d = StReject;
          status_d  = StReject;
          cause_d   = CauseLimit;
        end else if (dec_pop) begin
          exp_d   = exp_q + ExW'(1);
          sp_d    = sp_q - SpW'(1);
          state_d = S_TOP_RD;
        end else if (OvW'(sp_q) - OvW'(1) + OvW'(dec_bc) > OvW'(STACK_DEPTH)) begin
          verdict_d = StReject;
          status_d  = StReject;
          cause_d   = CauseOverflow;
        end else begin
          exp_d    = exp_q + ExW'(1);
          sp_d     = sp_q - SpW'(1);
          chosen_d = dec_rule;
          j_d      = dec_bc;
          state_d  = S_PUSH_RD;
        end
      end
      S_PUSH_RD: begin
        rs_raddr = rs_addr(chosen_q, j_q);
        state_d  = S_PUSH_WR;
      end
      S_PUSH_WR: begin
        stk_we    = 1'b1;
        stk_waddr = SaW'(sp_q);
        stk_wdata = rs_rdata;
        sp_d      = sp_q + SpW'(1);
        j_d       = j_q - SymW'(1);
        state_d   = (j_q == SymW'(1)) ? S_TOP_RD : S_PUSH_RD;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_cause_d  = (status_q == StReject) ? cause_q : CauseNone;
          out_depth_d  = 7'(sp_q);
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sp_q         <= '0;
      verdict_q    <= StRunning;
      rule_count_q <= RstRuleCount;
      start_q      <= RstStartSymbol;
      eps_q        <= RstEpsSymbol;
      end_q        <= RstEndMarker;
      out_valid_q  <= 1'b0;
      exp_q        <= '0;
    end else begin
      state_q      <= state_d;
      sp_q         <= sp_d;
      verdict_q    <= verdict_d;
      rule_count_q <= rule_count_d;
      start_q      <= start_d;
      eps_q        <= eps_d;
      end_q        <= end_d;
      out_valid_q  <= out_valid_d;
      exp_q        <= exp_d;
    end
  end

  // Working and result payload.
  always_ff @(posedge clk_i) begin
    sym_q         <= sym_d;
    top_q         <= top_d;
    r_q           <= r_d;
    m_q           <= m_d;
    have_q        <= have_d;
    can_null_q    <= can_null_d;
    first_empty_q <= first_empty_d;
    first_q       <= first_d;
    chosen_q      <= chosen_d;
    first_bc_q    <= first_bc_d;
    chosen_bc_q   <= chosen_bc_d;
    j_q           <= j_d;
    status_q      <= status_d;
    cause_q       <= cause_d;
    out_status_q  <= out_status_d;
    out_cause_q   <= out_cause_d;
    out_depth_q   <= out_depth_d;
  end

  // Rule symbol table.
  psp_ram #(.Width(8), .Depth(RULE_SLOTS * RULE_SYMBOLS)) u_rule_sym (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (symbol_i),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rdata)
  );

  // Rule length table.
  psp_ram #(.Width(4), .Depth(RULE_SLOTS)) u_rule_len (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (idx_w[RIdxW-1:0]),
    .wdata_i (rule_length_i),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  // Parse stack.
  psp_ram #(.Width(8), .Depth(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // The stack pointer never passes the stack depth.
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // A push only writes inside the stack.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH_WR) |-> (sp_q < SpW'(STACK_DEPTH)))
    else $error("push past end of stack");

  // The expansion count stays within its budget.
  a_exp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q <= ExW'(MAX_EXPANSIONS))
    else $error("expansion count over budget");

  // A reject result always carries a cause, other results never do.
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_status_q == StReject) == (out_cause_q != CauseNone)))
    else $error("reject cause inconsistent with status");

endmodule
